/* hw/rtl/record_play_key_controller_defines.svh */
// Assertion macros for the record/play key controller.
`ifndef RECORD_PLAY_KEY_CONTROLLER_DEFINES_SVH
`define RECORD_PLAY_KEY_CONTROLLER_DEFINES_SVH

`ifndef SYNTH

// expr holds at every clock edge out of reset
`define RPK_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("rpk assertion failed: always");

// cons holds in the same cycle as ante
`define RPK_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rpk assertion failed: implication");

// cons holds in the cycle after ante
`define RPK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rpk assertion failed: next cycle");

`else

`define RPK_ASSERT_ALWAYS(label, expr)
`define RPK_ASSERT_IMPLY(label, ante, cons)
`define RPK_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/rpk_pkg.sv */
// Types, constants and register indexes shared by the record/play key controller.
package rpk_pkg;

   localparam int STABLE_CAP_DEFAULT = 5;
   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int CNT_W      = 3;
   localparam int LONG_W     = 16;
   localparam int MAX_REC_W  = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MAX_REC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS   = 2'd0,
      CSR_MAX_RECORD   = 2'd1,
      CSR_STABLE_POLLS = 2'd2
   } rpk_csr_idx_type;

   localparam logic [LONG_W-1:0]    LONG_PRESS_RESET   = 16'd100;
   localparam logic [MAX_REC_W-1:0] MAX_RECORD_RESET   = 20'd500;
   localparam logic [CNT_W-1:0]     STABLE_POLLS_RESET = 3'd2;

   typedef struct packed {
      logic        record_key_level;
      logic        play_key_level;
      logic [31:0] time_now;
      logic        start_ok;
      logic        play_ok;
      logic        playback_done;
      logic        store_full;
   } rpk_req_type;

   typedef struct packed {
      logic recording;
      logic playing_recording;
      logic has_recording;
      logic start_record;
      logic stop_record;
      logic start_playback;
      logic stop_playback;
      logic start_failed;
   } rpk_rsp_type;

   typedef struct packed {
      logic [LONG_W-1:0]    long_press_ticks;
      logic [MAX_REC_W-1:0] max_record_ticks;
      logic [CNT_W-1:0]     stable_polls_needed;
   } rpk_cfg_type;

   typedef struct packed {
      logic             rec_last;
      logic             rec_stable;
      logic [CNT_W-1:0] rec_cnt;
      logic             armed;
      logic             recording;
      logic             has_rec;
      logic             playing;
      logic             play_last;
      logic             play_stable;
      logic [CNT_W-1:0] play_cnt;
   } rpk_flags_type;

   localparam rpk_flags_type FLAGS_RESET = '{
      rec_last:    1'b1,
      rec_stable:  1'b1,
      rec_cnt:     '0,
      armed:       1'b0,
      recording:   1'b0,
      has_rec:     1'b0,
      playing:     1'b0,
      play_last:   1'b1,
      play_stable: 1'b1,
      play_cnt:    '0
   };

endpackage

/* hw/rtl/rpk_step.sv */
// Per-request update of key debounce, long press and record/playback state.
module rpk_step
   import rpk_pkg::*;
#(
   parameter int STABLE_CAP = STABLE_CAP_DEFAULT,
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  rpk_req_type           req,
   input  rpk_cfg_type           cfg,
   input  rpk_flags_type         flags_cur,
   input  logic [TIME_WIDTH-1:0] press_time_cur,
   input  logic [TIME_WIDTH-1:0] start_time_cur,
   output rpk_flags_type         flags_nxt,
   output logic [TIME_WIDTH-1:0] press_time_nxt,
   output logic [TIME_WIDTH-1:0] start_time_nxt,
   output rpk_rsp_type           rsp
);

   localparam int SUM_W = (TIME_WIDTH > MAX_REC_W) ? TIME_WIDTH : MAX_REC_W;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(STABLE_CAP);

   rpk_flags_type         f;
   rpk_rsp_type           p;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] pt;
   logic [TIME_WIDTH-1:0] st;
   logic [SUM_W-1:0]      press_diff;
   logic [SUM_W-1:0]      max_diff;
   logic                  rec_lvl;
   logic                  play_lvl;
   logic                  play_press;

   always_comb begin
      f          = flags_cur;
      pt         = press_time_cur;
      st         = start_time_cur;
      p          = '0;
      now        = req.time_now[TIME_WIDTH-1:0];
      rec_lvl    = req.record_key_level;
      play_lvl   = req.play_key_level;
      play_press = 1'b0;
      press_diff = '0;
      max_diff   = '0;

      // record key
      if (rec_lvl == f.rec_last) begin
         if (f.rec_cnt < CAP) begin
            f.rec_cnt = f.rec_cnt + 1'b1;
         end
      end else begin
         f.rec_cnt  = '0;
         f.rec_last = rec_lvl;
      end

      if (f.recording && rec_lvl) begin
         f.recording   = 1'b0;
         f.has_rec     = 1'b1;
         p.stop_record = 1'b1;
         f.rec_stable  = 1'b1;
         f.armed       = 1'b0;
      end else begin
         if (f.rec_cnt >= cfg.stable_polls_needed && f.rec_stable != rec_lvl) begin
            f.rec_stable = rec_lvl;
            if (!rec_lvl) begin
               pt = now;
            end else if (f.armed) begin
               f.recording   = 1'b0;
               f.has_rec     = 1'b1;
               p.stop_record = 1'b1;
            end
            f.armed = 1'b0;
         end

         press_diff = SUM_W'(pt) + SUM_W'(cfg.long_press_ticks) - SUM_W'(now);
         if (!f.rec_stable && !f.armed && press_diff[TIME_WIDTH-1]) begin
            f.armed = 1'b1;
            if (!f.recording) begin
               if (f.playing) begin
                  f.playing       = 1'b0;
                  p.stop_playback = 1'b1;
               end
               if (req.start_ok) begin
                  f.recording    = 1'b1;
                  st             = now;
                  p.start_record = 1'b1;
               end else begin
                  p.start_failed = 1'b1;
               end
            end
         end

         max_diff = SUM_W'(st) + SUM_W'(cfg.max_record_ticks) - SUM_W'(now);
         if (f.recording && max_diff[TIME_WIDTH-1]) begin
            f.recording   = 1'b0;
            f.has_rec     = 1'b1;
            p.stop_record = 1'b1;
         end
      end

      // play key, ignored while recording
      if (!f.recording) begin
         if (play_lvl == f.play_last) begin
            if (f.play_cnt < CAP) begin
               f.play_cnt = f.play_cnt + 1'b1;
            end
         end else begin
            f.play_cnt  = '0;
            f.play_last = play_lvl;
         end
         if (f.play_cnt >= cfg.stable_polls_needed && f.play_stable != play_lvl) begin
            f.play_stable = play_lvl;
            play_press    = !play_lvl;
         end
         if (play_press) begin
            if (f.playing) begin
               f.playing       = 1'b0;
               p.stop_playback = 1'b1;
            end else if (req.play_ok) begin
               f.has_rec        = 1'b1;
               f.playing        = 1'b1;
               p.start_playback = 1'b1;
            end else begin
               f.has_rec      = 1'b0;
               p.start_failed = 1'b1;
            end
         end
      end

      if (req.store_full && f.recording) begin
         f.recording   = 1'b0;
         f.has_rec     = 1'b1;
         p.stop_record = 1'b1;
      end
      if (req.playback_done && f.playing) begin
         f.playing       = 1'b0;
         p.stop_playback = 1'b1;
      end

      p.recording         = f.recording;
      p.playing_recording = f.playing;
      p.has_recording     = f.has_rec;
   end

   assign flags_nxt      = f;
   assign press_time_nxt = pt;
   assign start_time_nxt = st;
   assign rsp            = p;

endmodule

/* hw/rtl/record_play_key_controller.sv */
// Top level of the record/play key controller: request, result and register stages.
//
// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   req_data  (rpk_req_type)
// rsp_      out        rsp_valid / rsp_stall   rsp_data  (rpk_rsp_type)
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One request per cycle unless rsp_stall holds; request register feeds result register.
// The state update sits in the single pass between those two registers.
// Synchronous reset restores register defaults and the key, recording and playback state.
// rsp_stall holds the result and backs up to req_stall in the same cycle.
// csr_ready is always high; writes to an unlisted index are dropped.
`include "record_play_key_controller_defines.svh"

module record_play_key_controller
   import rpk_pkg::*;
#(
   parameter int STABLE_CAP = STABLE_CAP_DEFAULT,
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rpk_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rpk_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic                  req_valid_ff, req_valid_in;
   rpk_req_type           req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rpk_rsp_type           rsp_ff;
   rpk_cfg_type           cfg_ff, cfg_in;
   rpk_flags_type         flags_ff, flags_in;
   logic [TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic [TIME_WIDTH-1:0] start_time_ff, start_time_in;
   rpk_rsp_type           step_rsp;
   logic                  advance;
   logic                  req_take;
   logic                  process;

   rpk_step #(
      .STABLE_CAP (STABLE_CAP),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .req            (req_ff),
      .cfg            (cfg_ff),
      .flags_cur      (flags_ff),
      .press_time_cur (press_time_ff),
      .start_time_cur (start_time_ff),
      .flags_nxt      (flags_in),
      .press_time_nxt (press_time_in),
      .start_time_nxt (start_time_in),
      .rsp            (step_rsp)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (rpk_csr_idx_type'(csr_index))
            CSR_LONG_PRESS:   cfg_in.long_press_ticks    = csr_data[LONG_W-1:0];
            CSR_MAX_RECORD:   cfg_in.max_record_ticks    = csr_data[MAX_REC_W-1:0];
            CSR_STABLE_POLLS: cfg_in.stable_polls_needed = csr_data[CNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff                   <= 1'b0;
         rsp_valid_ff                   <= 1'b0;
         cfg_ff.long_press_ticks        <= LONG_PRESS_RESET;
         cfg_ff.max_record_ticks        <= MAX_RECORD_RESET;
         cfg_ff.stable_polls_needed     <= STABLE_POLLS_RESET;
         flags_ff                       <= FLAGS_RESET;
         press_time_ff                  <= '0;
         start_time_ff                  <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (process) begin
            flags_ff      <= flags_in;
            press_time_ff <= press_time_in;
            start_time_ff <= start_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (process) begin
         rsp_ff <= step_rsp;
      end
   end

   `RPK_ASSERT_ALWAYS(a_rec_play_exclusive, !(flags_ff.recording && flags_ff.playing))
   `RPK_ASSERT_ALWAYS(a_cnt_capped, (flags_ff.rec_cnt <= CNT_W'(STABLE_CAP)) && (flags_ff.play_cnt <= CNT_W'(STABLE_CAP)))
   `RPK_ASSERT_IMPLY(a_empty_out_no_stall, !rsp_valid_ff, !req_stall)
   `RPK_ASSERT_NEXT(a_process_fills_out, process, rsp_valid_ff)
   `RPK_ASSERT_IMPLY(a_play_start_not_rec, rsp_valid_ff && rsp_ff.start_playback, !rsp_ff.recording)

endmodule
